@@ hw/rtl/hsde_pkg.sv @@
// ----------------------------------------------------------------------------
// hsde_pkg
// Shared types, constants and table functions of the halo speed density
// evaluator.
// ----------------------------------------------------------------------------
package hsde_pkg;

    localparam int SPEED_W     = 16;
    localparam int NORM_W      = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int ORBIT_W     = 14;

    localparam int EXP_TABLE_BITS_DEF = 8;
    localparam int XFRAC       = 16;
    localparam int QUOT_W      = 21;
    localparam int MAG_W       = 18;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int DVS_W       = 32;
    localparam int EXP_W       = 33;
    localparam int DIV_LAT     = QUOT_W + 1;
    localparam int EXP_LAT     = 4;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    localparam logic [CFG_ADDR_W-1:0] CFG_DISPERSION = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SUN        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORBIT      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COS        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ESCAPE     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_NORM       = 3'd5;

    typedef struct packed {
        logic                    zero;
        logic [2*NORM_W-1:0]     scaled;
    } hsde_side_t;

    function automatic logic [31:0] half_root(input int i);
        logic [31:0] r;
        case (i)
            1:  r = 32'd3037000500;
            2:  r = 32'd3611622603;
            3:  r = 32'd3938502376;
            4:  r = 32'd4112874773;
            5:  r = 32'd4202935004;
            6:  r = 32'd4248701965;
            7:  r = 32'd4271771997;
            8:  r = 32'd4283353945;
            9:  r = 32'd4289156690;
            10: r = 32'd4292061010;
            11: r = 32'd4293513907;
            12: r = 32'd4294240540;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [EXP_W-1:0] pow2_entry(input int j, input int tbits);
        logic [63:0] acc;
        acc = 64'h1_0000_0000;
        for (int b = 0; b < tbits; b++) begin
            if (((j >> b) & 1) == 1) begin
                acc = (acc * {32'd0, half_root(tbits - b)} + 64'h8000_0000) >> 32;
            end
        end
        return acc[EXP_W-1:0];
    endfunction

endpackage

@@ hw/rtl/hsde_div.sv @@
// ----------------------------------------------------------------------------
// hsde_div
// Pipelined restoring divider giving (sq * 2^16) / dvs, one quotient bit per
// stage, with a flag for quotients of 2^21 and above.
// ----------------------------------------------------------------------------
module hsde_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      valid_in,
    input  logic [hsde_pkg::SQ_W-1:0] sq,
    input  logic [hsde_pkg::DVS_W-1:0] dvs,
    output logic                      valid_out,
    output logic                      big,
    output logic [hsde_pkg::QUOT_W-1:0] quot
);
    import hsde_pkg::*;

    logic                vld_reg [0:QUOT_W];
    logic                big_reg [0:QUOT_W];
    logic [DVS_W-1:0]    rem_reg [0:QUOT_W];
    logic [DVS_W-1:0]    dvs_reg [0:QUOT_W];
    logic [QUOT_W-XFRAC-1:0] top_reg [0:QUOT_W];
    logic [QUOT_W-1:0]   q_reg   [0:QUOT_W];

    logic                big_next;

    assign big_next = {1'b0, sq} >= {dvs, 5'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            big_reg[0] <= big_next;
            rem_reg[0] <= big_next ? '0 : DVS_W'(sq >> 5);
            dvs_reg[0] <= dvs;
            top_reg[0] <= sq[QUOT_W-XFRAC-1:0];
            q_reg[0]   <= '0;
        end
    end

    for (genvar s = 1; s <= QUOT_W; s++) begin : g_stage
        localparam int BIT = QUOT_W - s;
        localparam int TOP_IDX = (BIT >= XFRAC) ? BIT - XFRAC : 0;
        logic [DVS_W:0]   shifted;
        logic             take;
        logic [QUOT_W-1:0] q_next;

        always_comb begin
            shifted = {rem_reg[s-1], 1'b0};
            if (BIT >= XFRAC) begin
                shifted[0] = top_reg[s-1][TOP_IDX];
            end
            take    = shifted >= {1'b0, dvs_reg[s-1]};
            q_next  = q_reg[s-1];
            q_next[BIT] = take;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                big_reg[s] <= big_reg[s-1];
                rem_reg[s] <= take ? DVS_W'(shifted - {1'b0, dvs_reg[s-1]})
                                   : shifted[DVS_W-1:0];
                dvs_reg[s] <= dvs_reg[s-1];
                top_reg[s] <= top_reg[s-1];
                q_reg[s]   <= q_next;
            end
        end
    end

    assign valid_out = vld_reg[QUOT_W];
    assign big       = big_reg[QUOT_W];
    assign quot      = q_reg[QUOT_W];

endmodule

@@ hw/rtl/hsde_exp.sv @@
// ----------------------------------------------------------------------------
// hsde_exp
// Four-stage exp(-x) unit: base change to powers of two, table lookup with
// linear interpolation, then a right shift by the integer exponent.
// ----------------------------------------------------------------------------
module hsde_exp #(
    parameter int EXP_TABLE_BITS = hsde_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic                        big,
    input  logic [hsde_pkg::QUOT_W-1:0] x,
    output logic                        valid_out,
    output logic [hsde_pkg::EXP_W-1:0]  e
);
    import hsde_pkg::*;

    localparam int TAB_N = 2 ** EXP_TABLE_BITS;
    localparam int LB    = XFRAC - EXP_TABLE_BITS;
    localparam int PW    = QUOT_W + 17;
    localparam int YW    = PW + 1 - XFRAC;
    localparam int KW    = YW - XFRAC;

    logic [EXP_W-1:0] tab [0:TAB_N];

    for (genvar g = 0; g < TAB_N; g++) begin : g_tab
        localparam logic [EXP_W-1:0] ENTRY = pow2_entry(g, EXP_TABLE_BITS);
        assign tab[g] = ENTRY;
    end
    assign tab[TAB_N] = EXP_W'(64'h8000_0000);

    logic [3:0]          vld_reg;
    logic [2:0]          big_reg;
    logic [PW-1:0]       p_reg;
    logic [EXP_W-1:0]    t0_reg;
    logic [EXP_W-1:0]    dt_reg;
    logic [LB-1:0]       rem_reg;
    logic [KW-1:0]       k_reg;
    logic [EXP_W-1:0]    t0b_reg;
    logic [EXP_W+LB-1:0] prod_reg;
    logic [KW-1:0]       kb_reg;
    logic [EXP_W-1:0]    e_reg;

    logic [PW:0]                ysum;
    logic [YW-1:0]              y;
    logic [EXP_TABLE_BITS:0]    j_idx;
    logic [EXP_W-1:0]           t0_next;
    logic [EXP_W-1:0]           t1_next;
    logic [EXP_W-1:0]           e_interp;

    always_comb begin
        ysum     = {1'b0, p_reg} + (PW+1)'(1 << (XFRAC - 1));
        y        = ysum[PW:XFRAC];
        j_idx    = {1'b0, y[XFRAC-1 -: EXP_TABLE_BITS]};
        t0_next  = tab[j_idx];
        t1_next  = tab[j_idx + 1'b1];
        e_interp = t0b_reg - prod_reg[LB +: EXP_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            big_reg  <= {big_reg[1:0], big};
            p_reg    <= PW'(x * LOG2E_Q16);
            t0_reg   <= t0_next;
            dt_reg   <= t0_next - t1_next;
            rem_reg  <= y[LB-1:0];
            k_reg    <= y[YW-1:XFRAC];
            t0b_reg  <= t0_reg;
            prod_reg <= dt_reg * rem_reg;
            kb_reg   <= k_reg;
            e_reg    <= big_reg[2] ? '0 : (e_interp >> kb_reg);
        end
    end

    assign valid_out = vld_reg[3];
    assign e         = e_reg;

endmodule

@@ hw/rtl/hsde_back.sv @@
// ----------------------------------------------------------------------------
// hsde_back
// Output stages: difference of the two exponentials, scaling by the norm
// times speed squared, and saturation into the result register.
// ----------------------------------------------------------------------------
module hsde_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic [hsde_pkg::EXP_W-1:0]  e1,
    input  logic [hsde_pkg::EXP_W-1:0]  e2,
    input  hsde_pkg::hsde_side_t        side,
    output logic                        valid_out,
    output logic [hsde_pkg::NORM_W-1:0] density
);
    import hsde_pkg::*;

    localparam int PRW = NORM_W + EXP_W;

    logic [2:0]              vld_reg;
    logic [1:0]              kill_reg;
    logic [EXP_W-1:0]        diff_reg;
    logic [2*NORM_W-1:0]     scaled_reg;
    logic [PRW-1:0]          hp_reg;
    logic [PRW-1:0]          lp_reg;
    logic [NORM_W-1:0]       density_reg;

    logic [PRW:0]            sum;
    logic [PRW-8:0]          r;

    always_comb begin
        sum = {1'b0, hp_reg} + (PRW+1)'(lp_reg >> NORM_W);
        r   = sum[PRW:8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], valid_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kill_reg[0] <= side.zero || (e2 >= e1);
            diff_reg    <= e1 - e2;
            scaled_reg  <= side.scaled;
            kill_reg[1] <= kill_reg[0];
            hp_reg      <= scaled_reg[2*NORM_W-1:NORM_W] * diff_reg;
            lp_reg      <= scaled_reg[NORM_W-1:0] * diff_reg;
            if (kill_reg[1]) begin
                density_reg <= '0;
            end else if (|r[PRW-8:NORM_W]) begin
                density_reg <= '1;
            end else begin
                density_reg <= r[NORM_W-1:0];
            end
        end
    end

    assign valid_out = vld_reg[2];
    assign density   = density_reg;

endmodule

@@ hw/rtl/halo_speed_density_eval.sv @@
// ----------------------------------------------------------------------------
// halo_speed_density_eval
// Lab-frame truncated Maxwellian speed density of the standard halo model,
// evaluated for one speed per transaction.
//
//   Channel    Dir  Payload                      Handshake
//   s_axis     in   tdata[15:0] speed            s_tvalid / s_tready
//   m_axis     out  tdata[31:0] density          m_tvalid / m_tready
//   cfg        in   cfg_addr, cfg_wdata          cfg_wr_en
//
// One speed is accepted every cycle while the result register is empty or taken.
// The latency is set by the bit-per-stage divider forming the squared ratio.
// All stages advance together whenever the result register is empty or taken.
// Reset is synchronous and active low and empties the pipeline.
// ----------------------------------------------------------------------------
module halo_speed_density_eval #(
    parameter int EXP_TABLE_BITS = hsde_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hsde_pkg::SPEED_W-1:0]    s_tdata,   // [15:0] speed
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hsde_pkg::NORM_W-1:0]     m_tdata,   // [31:0] density
    input  logic                            cfg_wr_en,
    input  logic [hsde_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [hsde_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import hsde_pkg::*;

    localparam int DLY_LEN = DIV_LAT + EXP_LAT;

    logic [15:0]          dispersion_reg;
    logic [15:0]          sun_reg;
    logic [ORBIT_W-1:0]   orbit_reg;
    logic signed [15:0]   cos_reg;
    logic [15:0]          escape_reg;
    logic [NORM_W-1:0]    norm_reg;

    logic                 en;

    logic                 a_valid_reg;
    logic [SPEED_W-1:0]   a_v_reg;
    logic signed [18:0]   a_vl_reg;

    logic                 b_valid_reg;
    logic                 b_zero_reg;
    logic [MAG_W-1:0]     b_m1_reg;
    logic [MAG_W-1:0]     b_m2_reg;
    logic [31:0]          b_vsq_reg;
    logic [DVS_W-1:0]     b_v0sq_reg;

    logic                 c_valid_reg;
    logic                 c_zero_reg;
    logic [SQ_W-1:0]      c_sq1_reg;
    logic [SQ_W-1:0]      c_sq2_reg;
    logic [2*NORM_W-1:0]  c_scaled_reg;
    logic [DVS_W-1:0]     c_v0sq_reg;

    hsde_side_t           dly_reg [0:DLY_LEN-1];

    logic signed [30:0]   orb_prod;
    logic [30:0]          orb_mag;
    logic [14:0]          orb_term;
    logic signed [18:0]   vl_next;
    logic signed [19:0]   v20;
    logic signed [19:0]   vl20;
    logic signed [19:0]   vesc20;
    logic signed [19:0]   d1;
    logic signed [19:0]   d2;
    logic [19:0]          d1_mag;
    logic [19:0]          d2_mag;
    logic                 zero_next;
    logic [15:0]          v0_eff;

    logic                 div1_valid;
    logic                 div1_big;
    logic [QUOT_W-1:0]    div1_quot;
    logic                 div2_valid;
    logic                 div2_big;
    logic [QUOT_W-1:0]    div2_quot;
    logic                 exp1_valid;
    logic                 exp2_valid;
    logic [EXP_W-1:0]     exp1_e;
    logic [EXP_W-1:0]     exp2_e;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dispersion_reg <= 16'd3520;
            sun_reg        <= 16'd3704;
            orbit_reg      <= 14'd240;
            cos_reg        <= 16'sd0;
            escape_reg     <= 16'd8800;
            norm_reg       <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DISPERSION: dispersion_reg <= cfg_wdata[15:0];
                CFG_SUN:        sun_reg        <= cfg_wdata[15:0];
                CFG_ORBIT:      orbit_reg      <= cfg_wdata[ORBIT_W-1:0];
                CFG_COS:        cos_reg        <= $signed(cfg_wdata[15:0]);
                CFG_ESCAPE:     escape_reg     <= cfg_wdata[15:0];
                CFG_NORM:       norm_reg       <= cfg_wdata[NORM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        orb_prod = 31'($signed({1'b0, orbit_reg}) * cos_reg);
        orb_mag  = orb_prod[30] ? 31'(-orb_prod) : 31'(orb_prod);
        orb_term = 15'((orb_mag + 31'd8192) >> 14);
        vl_next  = orb_prod[30] ? $signed({3'b0, sun_reg}) - $signed({4'b0, orb_term})
                                : $signed({3'b0, sun_reg}) + $signed({4'b0, orb_term});

        v20    = $signed({4'b0, a_v_reg});
        vl20   = {a_vl_reg[18], a_vl_reg};
        vesc20 = $signed({4'b0, escape_reg});
        d1     = v20 - vl20;
        zero_next = 1'b0;
        if (a_v_reg == '0) begin
            d2        = vesc20;
            zero_next = 1'b1;
        end else if (v20 < vesc20 - vl20) begin
            d2 = v20 + vl20;
        end else if (v20 < vesc20 + vl20) begin
            d2 = vesc20;
        end else begin
            d2        = vesc20;
            zero_next = 1'b1;
        end
        d1_mag = d1[19] ? 20'(-d1) : 20'(d1);
        d2_mag = d2[19] ? 20'(-d2) : 20'(d2);
        v0_eff = (dispersion_reg == '0) ? 16'd1 : dispersion_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_v_reg      <= s_tdata;
            a_vl_reg     <= vl_next;
            b_zero_reg   <= zero_next;
            b_m1_reg     <= d1_mag[MAG_W-1:0];
            b_m2_reg     <= d2_mag[MAG_W-1:0];
            b_vsq_reg    <= a_v_reg * a_v_reg;
            b_v0sq_reg   <= v0_eff * v0_eff;
            c_zero_reg   <= b_zero_reg;
            c_sq1_reg    <= b_m1_reg * b_m1_reg;
            c_sq2_reg    <= b_m2_reg * b_m2_reg;
            c_scaled_reg <= norm_reg * b_vsq_reg;
            c_v0sq_reg   <= b_v0sq_reg;
            dly_reg[0]   <= '{zero: c_zero_reg, scaled: c_scaled_reg};
            for (int i = 1; i < DLY_LEN; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    hsde_div u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (c_valid_reg),
        .sq        (c_sq1_reg),
        .dvs       (c_v0sq_reg),
        .valid_out (div1_valid),
        .big       (div1_big),
        .quot      (div1_quot)
    );

    hsde_div u_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (c_valid_reg),
        .sq        (c_sq2_reg),
        .dvs       (c_v0sq_reg),
        .valid_out (div2_valid),
        .big       (div2_big),
        .quot      (div2_quot)
    );

    hsde_exp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (div1_valid),
        .big       (div1_big),
        .x         (div1_quot),
        .valid_out (exp1_valid),
        .e         (exp1_e)
    );

    hsde_exp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (div2_valid),
        .big       (div2_big),
        .x         (div2_quot),
        .valid_out (exp2_valid),
        .e         (exp2_e)
    );

    hsde_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (exp1_valid),
        .e1        (exp1_e),
        .e2        (exp2_e),
        .side      (dly_reg[DLY_LEN-1]),
        .valid_out (m_tvalid),
        .density   (m_tdata)
    );

    a_paths_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        exp1_valid == exp2_valid)
        else $error("Exponential paths lost alignment.");

    a_zero_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        en && a_valid_reg && a_v_reg == '0 |=> b_valid_reg && b_zero_reg)
        else $error("Zero speed was not flagged.");

    a_empty_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("Result valid right after reset.");

endmodule
